FILE: rtl/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// ritoa_pkg
// Shared widths, character codes and control types of the radix
// integer-to-ascii converter.
// ----------------------------------------------------------------------------
package ritoa_pkg;

	// value and text sizes
	localparam int VALUE_WIDTH = 32;
	localparam int MAX_DIGITS  = 32;
	localparam int RADIX_W     = 5;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;

	// divider: quotient bits resolved per cycle
	localparam int STEP_BITS = 8;
	localparam int DIV_STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int QUOT_W    = DIV_STEPS * STEP_BITS;
	localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	// digit store addressing
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int SHIFT_W = 3;

	// bases with special handling
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_BIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_QUA = 5'd4;
	localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
	localparam logic [CHAR_W-1:0] CH_B     = 8'h62;

	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// control of the shared digit unit
	typedef struct packed {
		logic               pow2;
		logic [SHIFT_W-1:0] shift;
		logic [RADIX_W-1:0] base;
	} div_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

FILE: rtl/ritoa_value_if.sv
// ----------------------------------------------------------------------------
// ritoa_value_if
// Input channel: one signed value and its number base per transaction.
// ----------------------------------------------------------------------------
interface ritoa_value_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [ritoa_pkg::VALUE_WIDTH-1:0]  value;
	logic        [ritoa_pkg::RADIX_W-1:0]      radix;

	modport source (output valid, output value, output radix, input ready);
	modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: rtl/ritoa_char_if.sv
// ----------------------------------------------------------------------------
// ritoa_char_if
// Output channel: one ascii character and an end-of-text flag per transaction.
// ----------------------------------------------------------------------------
interface ritoa_char_if;
	logic                          valid;
	logic                          ready;
	logic [ritoa_pkg::CHAR_W-1:0]  character;
	logic                          last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

FILE: rtl/ritoa_digit_unit.sv
// ----------------------------------------------------------------------------
// ritoa_digit_unit
// Shared arithmetic of the converter: one restoring-division pass over
// STEP_BITS quotient bits, or a full digit by shift and mask for bases
// that are powers of two.
// ----------------------------------------------------------------------------
module ritoa_digit_unit (
	input  ritoa_pkg::div_ctl_t                ctl,
	input  logic [ritoa_pkg::QUOT_W-1:0]       quot,
	input  logic [ritoa_pkg::DIGIT_W-1:0]      rem,
	output logic [ritoa_pkg::QUOT_W-1:0]       quot_next,
	output logic [ritoa_pkg::DIGIT_W-1:0]      rem_next
);

	// restoring division, msb first, partial remainder stays below base
	always_comb begin
		logic [ritoa_pkg::DIGIT_W:0]     t;
		logic [ritoa_pkg::DIGIT_W-1:0]   r;
		logic [ritoa_pkg::STEP_BITS-1:0] qb;
		logic [ritoa_pkg::RADIX_W-1:0]   base_mask;
		r  = rem;
		qb = '0;
		for (int i = 0; i < ritoa_pkg::STEP_BITS; i++) begin
			t = {r, quot[ritoa_pkg::QUOT_W-1-i]};
			if (t >= ctl.base) begin
				qb[ritoa_pkg::STEP_BITS-1-i] = 1'b1;
				t = t - ctl.base;
			end
			r = t[ritoa_pkg::DIGIT_W-1:0];
		end
		base_mask = ctl.base - ritoa_pkg::RADIX_W'(1);

		if (ctl.pow2) begin
			quot_next = quot >> ctl.shift;
			rem_next  = quot[ritoa_pkg::DIGIT_W-1:0] & base_mask[ritoa_pkg::DIGIT_W-1:0];
		end else begin
			quot_next = (quot << ritoa_pkg::STEP_BITS) | ritoa_pkg::QUOT_W'(qb);
			rem_next  = r;
		end
	end

endmodule

FILE: rtl/radix_integer_to_ascii_core.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii_core
// Converts a signed value to its ascii text in base 2 to 16, one
// character per output transaction, the final one flagged by last.
// ----------------------------------------------------------------------------
// Usage
// value_ch takes a signed value and a radix; radix below 2 counts as 2 and
// above 16 counts as 16. char_ch returns the text: '-' first for a negative
// value in base 10, "0x", "0o" or "0b" first in bases 16, 8 and 2, then the
// upper-case digits, most significant first. Zero is "0" alone.
// Timing: the digits come from one shared unit. In bases 2, 4, 8 and 16 it
// yields a digit each cycle; in other bases it resolves 8 quotient bits a
// cycle. After the digits, the prefix and one digit-store read lead into
// one character per cycle unless the receiver stalls. value_ch.ready is
// high only while no item is in progress; the next item is taken while
// the last character still waits in the output register. A stalled
// receiver holds the character in place and stalls the prefix and digit
// output, while the division of a new item goes on.
// Reset clears the sequencer and the output valid; the digit store holds
// no reset value and is always written before it is read.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii_core (
	input  logic            clk,
	input  logic            arst_n,
	ritoa_value_if.sink     value_ch,
	ritoa_char_if.source    char_ch
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_PFX1  = 3'd2;
	localparam logic [2:0] S_PFX2  = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]                          state_q, state_d;
	logic [ritoa_pkg::QUOT_W-1:0]        quot_q, quot_d, quot_next;
	logic [ritoa_pkg::DIGIT_W-1:0]       rem_q, rem_d, rem_next;
	logic [ritoa_pkg::STEP_W-1:0]        step_q, step_d;
	logic [ritoa_pkg::CNT_W-1:0]         cnt_q, cnt_d, cnt_inc, cnt_dec;
	ritoa_pkg::div_ctl_t                 ctl_q, ctl_d, ctl_in;
	logic                                minus_q, minus_d;
	logic                                pfx2_q, pfx2_d;
	logic [ritoa_pkg::CHAR_W-1:0]        letter_q, letter_d;
	logic                                out_valid_q, out_valid_d;
	logic [ritoa_pkg::CHAR_W-1:0]        out_char_q, out_char_d;
	logic                                out_last_q, out_last_d;

	logic [ritoa_pkg::DIGIT_W-1:0]       mem [ritoa_pkg::MAX_DIGITS];
	logic [ritoa_pkg::DIGIT_W-1:0]       rd_q;
	logic                                mem_we, mem_re;

	logic                                in_acc, slot_free, digit_done;
	logic                                neg_in;
	logic [ritoa_pkg::VALUE_WIDTH-1:0]   mag_in;
	logic [ritoa_pkg::RADIX_W-1:0]       base_in;

	assign value_ch.ready  = (state_q == S_IDLE);
	assign in_acc          = value_ch.valid && value_ch.ready;
	assign slot_free       = !out_valid_q || char_ch.ready;
	assign char_ch.valid     = out_valid_q;
	assign char_ch.character = out_char_q;
	assign char_ch.last      = out_last_q;

	assign cnt_inc = cnt_q + ritoa_pkg::CNT_W'(1);
	assign cnt_dec = cnt_q - ritoa_pkg::CNT_W'(1);

	// magnitude and base of the incoming transaction
	always_comb begin
		neg_in = value_ch.value[ritoa_pkg::VALUE_WIDTH-1];
		mag_in = neg_in ? (~value_ch.value + ritoa_pkg::VALUE_WIDTH'(1)) : value_ch.value;
		if (value_ch.radix < ritoa_pkg::RADIX_MIN) begin
			base_in = ritoa_pkg::RADIX_MIN;
		end else if (value_ch.radix > ritoa_pkg::RADIX_MAX) begin
			base_in = ritoa_pkg::RADIX_MAX;
		end else begin
			base_in = value_ch.radix;
		end
		ctl_in.base = base_in;
		ctl_in.pow2 = base_in inside {ritoa_pkg::RADIX_BIN, ritoa_pkg::RADIX_QUA,
			ritoa_pkg::RADIX_OCT, ritoa_pkg::RADIX_HEX};
		case (base_in)
			ritoa_pkg::RADIX_BIN: ctl_in.shift = 3'd1;
			ritoa_pkg::RADIX_QUA: ctl_in.shift = 3'd2;
			ritoa_pkg::RADIX_OCT: ctl_in.shift = 3'd3;
			default:              ctl_in.shift = 3'd4;
		endcase
	end

	// shared digit unit
	ritoa_digit_unit u_digit_unit (
		.ctl       (ctl_q),
		.quot      (quot_q),
		.rem       (rem_q),
		.quot_next (quot_next),
		.rem_next  (rem_next)
	);

	assign digit_done = ctl_q.pow2 || (step_q == ritoa_pkg::STEP_W'(ritoa_pkg::DIV_STEPS - 1));

	// sequencer
	always_comb begin
		state_d     = state_q;
		quot_d      = quot_q;
		rem_d       = rem_q;
		step_d      = step_q;
		cnt_d       = cnt_q;
		ctl_d       = ctl_q;
		minus_d     = minus_q;
		pfx2_d      = pfx2_q;
		letter_d    = letter_q;
		out_valid_d = out_valid_q && !char_ch.ready;
		out_char_d  = out_char_q;
		out_last_d  = out_last_q;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					quot_d  = ritoa_pkg::QUOT_W'(mag_in);
					rem_d   = '0;
					step_d  = '0;
					cnt_d   = '0;
					ctl_d   = ctl_in;
					minus_d = neg_in && (base_in == ritoa_pkg::RADIX_DEC);
					pfx2_d  = (mag_in != '0) && (base_in inside {ritoa_pkg::RADIX_HEX,
						ritoa_pkg::RADIX_OCT, ritoa_pkg::RADIX_BIN});
					case (base_in)
						ritoa_pkg::RADIX_HEX: letter_d = ritoa_pkg::CH_X;
						ritoa_pkg::RADIX_OCT: letter_d = ritoa_pkg::CH_O;
						default:              letter_d = ritoa_pkg::CH_B;
					endcase
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				quot_d = quot_next;
				if (digit_done) begin
					mem_we = 1'b1;
					cnt_d  = cnt_inc;
					rem_d  = '0;
					step_d = '0;
					if (quot_next == '0 || cnt_inc == ritoa_pkg::CNT_W'(ritoa_pkg::MAX_DIGITS)) begin
						state_d = (minus_q || pfx2_q) ? S_PFX1 : S_FETCH;
					end
				end else begin
					rem_d  = rem_next;
					step_d = step_q + ritoa_pkg::STEP_W'(1);
				end
			end
			S_PFX1: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					out_char_d  = minus_q ? ritoa_pkg::CH_MINUS : ritoa_pkg::CH_ZERO;
					out_last_d  = 1'b0;
					state_d     = pfx2_q ? S_PFX2 : S_FETCH;
				end
			end
			S_PFX2: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					out_char_d  = letter_q;
					out_last_d  = 1'b0;
					state_d     = S_FETCH;
				end
			end
			S_FETCH: begin
				mem_re  = 1'b1;
				cnt_d   = cnt_dec;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (slot_free) begin
					out_valid_d = 1'b1;
					out_char_d  = ritoa_pkg::digit_char(rd_q);
					out_last_d  = (cnt_q == '0);
					if (cnt_q == '0) begin
						state_d = S_IDLE;
					end else begin
						mem_re = 1'b1;
						cnt_d  = cnt_dec;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		quot_q     <= quot_d;
		rem_q      <= rem_d;
		ctl_q      <= ctl_d;
		minus_q    <= minus_d;
		pfx2_q     <= pfx2_d;
		letter_q   <= letter_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	// digit store, least significant digit at index zero
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[ritoa_pkg::IDX_W-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_q <= mem[cnt_dec[ritoa_pkg::IDX_W-1:0]];
		end
	end

endmodule

FILE: rtl/ritoa_checker.sv
// ----------------------------------------------------------------------------
// ritoa_checker
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ritoa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [ritoa_pkg::CHAR_W-1:0]  out_char,
	input logic                          out_last
);

	// a held character stays put until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output transaction changed while stalled");

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in progress");

	// text not finished means no new item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready in the middle of a text");

	// only digits, sign and prefix letters appear
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char >= 8'h30 && out_char <= 8'h39) ||
			(out_char >= 8'h41 && out_char <= 8'h46) ||
			out_char == 8'h2D || out_char == 8'h78 ||
			out_char == 8'h6F || out_char == 8'h62)
		else $error("unexpected character code");

endmodule

bind radix_integer_to_ascii_core ritoa_checker u_ritoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (value_ch.valid),
	.in_ready  (value_ch.ready),
	.out_valid (char_ch.valid),
	.out_ready (char_ch.ready),
	.out_char  (char_ch.character),
	.out_last  (char_ch.last)
);
